FILE: hw/rtl/ffha_pkg.sv
package ffha_pkg;

  // Field widths fixed by the interface
  localparam int unsigned OFS_W  = 20;
  localparam int unsigned REQ_W  = 21;
  localparam int unsigned SIZE_W = 22;
  localparam int unsigned SPL_W  = 23;

  // Arena geometry
  localparam int unsigned ARENA_BYTES  = 1024 * 1024;
  localparam int unsigned HEADER_BYTES = 16;
  localparam int unsigned MIN_SPLIT    = 16;
  localparam int unsigned ROUND_ADD    = 15;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_REALLOC = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_OOM   = 2'd1,
    STAT_FREED = 2'd2
  } stat_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_UP,
    S_INS,
    S_TAKE,
    S_RDP,
    S_RDN,
    S_MERGE,
    S_DOWN,
    S_DONE
  } state_e;

  typedef enum logic [1:0] {
    J_ALLOC,
    J_FREE,
    J_REALLOC,
    J_REFREE
  } job_e;

  // One row of the block table
  typedef struct packed {
    logic [OFS_W-1:0] start;
    logic [OFS_W-1:0] pay;
    logic             free;
  } entry_t;

  // Result word handed from the sequencer to the output register
  typedef struct packed {
    logic [OFS_W-1:0] offset;
    stat_e            status;
    logic [REQ_W-1:0] copy;
  } res_t;

  localparam entry_t RESET_ENTRY = '{
    start: '0,
    pay:   OFS_W'(ARENA_BYTES - HEADER_BYTES),
    free:  1'b1
  };

endpackage

FILE: hw/rtl/ffha_table.sv
module ffha_table
  import ffha_pkg::*;
#(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  entry_t        wdata_i,
  input  logic [AW-1:0] raddr_i,
  output entry_t        rdata_o
);

  entry_t mem [DEPTH];
  entry_t rdata_q;
  logic   w0_q;
  logic   rinit_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  // Entry zero reads as the single arena-wide free block until first written.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w0_q    <= 1'b0;
      rinit_q <= 1'b0;
    end else begin
      rinit_q <= (raddr_i == '0) && !w0_q;
      if (we_i && (waddr_i == '0)) begin
        w0_q <= 1'b1;
      end
    end
  end

  assign rdata_o = rinit_q ? RESET_ENTRY : rdata_q;

endmodule

FILE: hw/rtl/ffha_seq.sv
module ffha_seq
  import ffha_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = 256,
  parameter int unsigned AW         = 8,
  parameter int unsigned PW         = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [1:0]       op_i,
  input  logic [REQ_W-1:0] req_size_i,
  input  logic [OFS_W-1:0] ptr_offset_i,
  input  logic             take_i,
  output logic             busy_o,
  output logic             done_o,
  output res_t             res_o,
  output logic [AW-1:0]    raddr_o,
  input  entry_t           rdata_i,
  output logic             we_o,
  output logic [AW-1:0]    waddr_o,
  output entry_t           wdata_o
);

  localparam logic [OFS_W-1:0] HDR    = OFS_W'(HEADER_BYTES);
  localparam logic [PW-1:0]    PMAX   = PW'(MAX_BLOCKS);

  state_e state_q, state_d;
  job_e   job_q, job_d;
  logic   fit_q, fit_d;
  logic   rzero_q, rzero_d;
  logic [OFS_W-1:0]  ptr_q, ptr_d;
  logic [SIZE_W-1:0] size_q, size_d;
  logic [SPL_W-1:0]  sz32_q, sz32_d;
  logic [PW-1:0] cnt_q, cnt_d;
  logic [PW-1:0] idx_q, idx_d;
  logic [PW-1:0] chk_q, chk_d;
  logic [PW-1:0] cidx_q, cidx_d;
  logic [PW-1:0] src_q, src_d;
  logic [PW-1:0] wa_q, wa_d;
  logic [1:0]    k_q, k_d;
  logic   pend_q, pend_d;
  logic   split_q, split_d;
  logic   pf_q, pf_d;
  entry_t cur_q, cur_d;
  logic [OFS_W-1:0] acc_q, acc_d;
  logic [OFS_W-1:0] pst_q, pst_d;
  res_t   res_q, res_d;

  // Request decode helpers
  logic [SIZE_W-1:0] rnd_sum;
  logic [SIZE_W-1:0] rnd_size;
  logic              hit_fit;
  logic              hit_find;
  logic              hit;
  logic              nf;
  logic [OFS_W-1:0]  mpay;
  logic [PW-1:0]     rpos;

  assign rnd_sum  = {1'b0, req_size_i} + SIZE_W'(ROUND_ADD);
  assign rnd_size = {rnd_sum[SIZE_W-1:4], 4'b0000};

  // Shared compare unit for both scan kinds
  assign hit_fit  = rdata_i.free && ({2'b00, rdata_i.pay} >= size_q);
  assign hit_find = !rdata_i.free &&
                    (({1'b0, rdata_i.start} + {1'b0, HDR}) == {1'b0, ptr_q});
  assign hit      = pend_q && (fit_q ? hit_fit : hit_find);

  // Merge arithmetic for the right neighbor
  assign nf   = ((cidx_q + PW'(1)) < cnt_q) && rdata_i.free;
  assign mpay = nf ? (acc_q + HDR + rdata_i.pay) : acc_q;
  assign rpos = pf_q ? cidx_q : (cidx_q + PW'(1));

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      job_q   <= J_ALLOC;
      cnt_q   <= PW'(1);
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      job_q   <= job_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    fit_q   <= fit_d;
    rzero_q <= rzero_d;
    ptr_q   <= ptr_d;
    size_q  <= size_d;
    sz32_q  <= sz32_d;
    idx_q   <= idx_d;
    chk_q   <= chk_d;
    cidx_q  <= cidx_d;
    src_q   <= src_d;
    wa_q    <= wa_d;
    k_q     <= k_d;
    split_q <= split_d;
    pf_q    <= pf_d;
    cur_q   <= cur_d;
    acc_q   <= acc_d;
    pst_q   <= pst_d;
    res_q   <= res_d;
  end

  // Next state and table control
  always_comb begin
    state_d = state_q;
    job_d   = job_q;
    fit_d   = fit_q;
    rzero_d = rzero_q;
    ptr_d   = ptr_q;
    size_d  = size_q;
    sz32_d  = sz32_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    chk_d   = chk_q;
    cidx_d  = cidx_q;
    src_d   = src_q;
    wa_d    = wa_q;
    k_d     = k_q;
    pend_d  = pend_q;
    split_d = split_q;
    pf_d    = pf_q;
    cur_d   = cur_q;
    acc_d   = acc_q;
    pst_d   = pst_q;
    res_d   = res_q;
    raddr_o = idx_q[AW-1:0];
    we_o    = 1'b0;
    waddr_o = cidx_q[AW-1:0];
    wdata_o = cur_q;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          rzero_d = (req_size_i == '0);
          ptr_d   = ptr_offset_i;
          size_d  = rnd_size;
          sz32_d  = {1'b0, rnd_size} + SPL_W'(HEADER_BYTES + MIN_SPLIT);
          res_d   = '{offset: '0, status: STAT_OK, copy: '0};
          idx_d   = '0;
          pend_d  = 1'b0;
          case (op_e'(op_i))
            OP_ALLOC: begin
              job_d   = J_ALLOC;
              fit_d   = 1'b1;
              state_d = S_SCAN;
            end
            OP_FREE: begin
              job_d   = J_FREE;
              fit_d   = 1'b0;
              state_d = (ptr_offset_i == '0) ? S_DONE : S_SCAN;
            end
            OP_REALLOC: begin
              job_d   = (ptr_offset_i == '0) ? J_ALLOC : J_REALLOC;
              fit_d   = (ptr_offset_i == '0);
              state_d = S_SCAN;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      // Walk the table one entry a cycle; read data returns in the cycle after its address.
      S_SCAN: begin
        if (idx_q < cnt_q) begin
          idx_d  = idx_q + PW'(1);
          chk_d  = idx_q;
          pend_d = 1'b1;
        end else begin
          pend_d = 1'b0;
        end
        if (hit) begin
          cur_d  = rdata_i;
          cidx_d = chk_q;
        end
        if (hit || (idx_q >= cnt_q)) begin
          pend_d = 1'b0;
          if (fit_q) begin
            if (hit) begin
              split_d = ({3'b000, rdata_i.pay} >= sz32_q) && (cnt_q < PMAX);
              src_d   = cnt_q - PW'(1);
              state_d = (({3'b000, rdata_i.pay} >= sz32_q) && (cnt_q < PMAX)) ?
                        S_UP : S_TAKE;
            end else begin
              res_d.status = STAT_OOM;
              res_d.copy   = '0;
              state_d      = S_DONE;
            end
          end else begin
            case (job_q)
              J_REALLOC: begin
                if (rzero_q) begin
                  res_d.status = STAT_FREED;
                  state_d      = hit ? S_RDP : S_DONE;
                end else if (!hit) begin
                  res_d.status = STAT_OOM;
                  state_d      = S_DONE;
                end else if ({2'b00, rdata_i.pay} >= size_q) begin
                  res_d.offset = ptr_q;
                  state_d      = S_DONE;
                end else begin
                  // Too small: look for a new block, then release this one.
                  res_d.copy = {1'b0, rdata_i.pay};
                  fit_d      = 1'b1;
                  idx_d      = '0;
                end
              end
              default: begin
                state_d = hit ? S_RDP : S_DONE;
              end
            endcase
          end
        end
      end

      // Open a slot after the chosen block, moving entries up from the end.
      S_UP: begin
        if (pend_q) begin
          we_o    = 1'b1;
          waddr_o = wa_q[AW-1:0];
          wdata_o = rdata_i;
        end
        if (src_q > cidx_q) begin
          raddr_o = src_q[AW-1:0];
          wa_d    = src_q + PW'(1);
          src_d   = src_q - PW'(1);
          pend_d  = 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            state_d = S_INS;
          end
        end
      end

      // Free remainder of a split block
      S_INS: begin
        we_o          = 1'b1;
        waddr_o       = cidx_q[AW-1:0] + AW'(1);
        wdata_o.start = cur_q.start + HDR + size_q[OFS_W-1:0];
        wdata_o.pay   = cur_q.pay - size_q[OFS_W-1:0] - HDR;
        wdata_o.free  = 1'b1;
        state_d       = S_TAKE;
      end

      S_TAKE: begin
        we_o          = 1'b1;
        waddr_o       = cidx_q[AW-1:0];
        wdata_o.start = cur_q.start;
        wdata_o.pay   = split_q ? size_q[OFS_W-1:0] : cur_q.pay;
        wdata_o.free  = 1'b0;
        if (split_q) begin
          cnt_d = cnt_q + PW'(1);
        end
        res_d.offset = cur_q.start + HDR;
        if (job_q == J_REALLOC) begin
          // The old block may have moved by one slot: find it again.
          job_d   = J_REFREE;
          fit_d   = 1'b0;
          idx_d   = '0;
          pend_d  = 1'b0;
          state_d = S_SCAN;
        end else begin
          state_d = S_DONE;
        end
      end

      S_RDP: begin
        raddr_o = cidx_q[AW-1:0] - AW'(1);
        state_d = S_RDN;
      end

      // Left neighbor arrives; fold it in and fetch the right neighbor.
      S_RDN: begin
        pf_d    = (cidx_q != '0) && rdata_i.free;
        acc_d   = ((cidx_q != '0) && rdata_i.free) ?
                  (rdata_i.pay + HDR + cur_q.pay) : cur_q.pay;
        pst_d   = ((cidx_q != '0) && rdata_i.free) ? rdata_i.start : cur_q.start;
        raddr_o = cidx_q[AW-1:0] + AW'(1);
        state_d = S_MERGE;
      end

      S_MERGE: begin
        we_o          = 1'b1;
        waddr_o       = pf_q ? (cidx_q[AW-1:0] - AW'(1)) : cidx_q[AW-1:0];
        wdata_o.start = pst_q;
        wdata_o.pay   = mpay;
        wdata_o.free  = 1'b1;
        k_d           = {1'b0, pf_q} + {1'b0, nf};
        src_d         = rpos + PW'({1'b0, pf_q} + {1'b0, nf});
        pend_d        = 1'b0;
        state_d       = (pf_q || nf) ? S_DOWN : S_DONE;
      end

      // Close the gap left by merged entries.
      S_DOWN: begin
        if (pend_q) begin
          we_o    = 1'b1;
          waddr_o = wa_q[AW-1:0];
          wdata_o = rdata_i;
        end
        if (src_q < cnt_q) begin
          raddr_o = src_q[AW-1:0];
          wa_d    = src_q - PW'(k_q);
          src_d   = src_q + PW'(1);
          pend_d  = 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            cnt_d   = cnt_q - PW'(k_q);
            state_d = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (take_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);
  assign res_o  = res_q;

  // The table never empties and never overflows.
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) && (cnt_q <= PMAX))
    else $error("block count out of range");

  // A failed request hands out nothing.
  a_oom_null: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) && (res_q.status == STAT_OOM) |->
      (res_q.offset == '0) && (res_q.copy == '0))
    else $error("failure result carries data");

  // A copy length comes only with a successful move.
  a_copy_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) && (res_q.copy != '0) |->
      (res_q.status == STAT_OK) && (res_q.offset != '0))
    else $error("copy length without a new block");

  // Insert sweep stays inside the grown table.
  a_up_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UP) && pend_q |-> (wa_q <= cnt_q) && (cnt_q < PMAX))
    else $error("insert shift beyond table");

  // Entering a removal always drops one or two entries.
  a_down_k: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DOWN) |-> (k_q != 2'd0) && (cnt_q > PW'(k_q)))
    else $error("bad removal distance");

endmodule

FILE: hw/rtl/first_fit_heap_allocator_core.sv
// Channel   Direction  Handshake                  Word
// request   in         in_valid_i / in_stall_o    op_i, req_size_i, ptr_offset_i
// response  out        out_valid_o / out_stall_i  result_offset_o, status_o, copy_len_o
//
// One request at a time; one response word per request.
// A table scan reads the entries in order; an alloc is one scan and, on a split, an
// insert shift over the entries above the chosen block; a free is one scan, a merge
// (S_RDP, S_RDN, S_MERGE) and a removal shift. A moving realloc runs up to three scans.
// All of it runs through the block table, one read and one write per cycle.
// Reset leaves one free block covering the arena; no clearing pass is needed.
// The response register frees the sequencer, so a new request is taken while a
// response is still stalled; the next response waits until the old one is taken.
module first_fit_heap_allocator_core
  import ffha_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       op_i,
  input  logic [REQ_W-1:0] req_size_i,
  input  logic [OFS_W-1:0] ptr_offset_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [OFS_W-1:0] result_offset_o,
  output logic [1:0]       status_o,
  output logic [REQ_W-1:0] copy_len_o
);

  localparam int unsigned AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned PW = $clog2(MAX_BLOCKS + 1) + 1;

  logic          busy;
  logic          done;
  logic          take;
  logic          start;
  res_t          res;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic          we;
  entry_t        wdata;
  entry_t        rdata;
  logic          out_vld_q, out_vld_d;
  res_t          out_q;

  assign start = in_valid_i && !busy;
  assign take  = done && (!out_vld_q || !out_stall_i);

  ffha_seq #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .AW         (AW),
    .PW         (PW)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .op_i         (op_i),
    .req_size_i   (req_size_i),
    .ptr_offset_i (ptr_offset_i),
    .take_i       (take),
    .busy_o       (busy),
    .done_o       (done),
    .res_o        (res),
    .raddr_o      (raddr),
    .rdata_i      (rdata),
    .we_o         (we),
    .waddr_o      (waddr),
    .wdata_o      (wdata)
  );

  ffha_table #(
    .DEPTH (MAX_BLOCKS),
    .AW    (AW)
  ) u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Response register
  always_comb begin
    out_vld_d = out_vld_q;
    if (take) begin
      out_vld_d = 1'b1;
    end else if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= res;
    end
  end

  assign in_stall_o      = busy;
  assign out_valid_o     = out_vld_q;
  assign result_offset_o = out_q.offset;
  assign status_o        = out_q.status;
  assign copy_len_o      = out_q.copy;

endmodule
